>>> src/iida_pkg.sv
package iida_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = 7;
  localparam int WORD_W   = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    REQ_DISPLAY = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_DELETE  = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_SHOW
  } iida_state_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [CNT_W-1:0]        position;
    logic signed [WORD_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] element_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         fill_count;
    logic                     last;
  } rsp_word_t;

  // control broadcast to every cell
  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         tail;
    logic signed [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> src/indexed_insert_delete_array.sv
// Channel   | Ports                    | Handshake
// ----------+--------------------------+-------------------------------------
// request   | req (req_word_t)         | taken on clk when start && !busy
// result    | result (rsp_word_t)      | one word per cycle with strobe high
//
// Insert and delete shift every cell at once, and the result word shows on
// the following cycle. A non-empty display holds busy while its words
// stream out, and the next request is taken once busy drops. In each busy
// cycle the occupied cells rotate one place toward cell 0, which feeds the
// result register, so the words show one per cycle, and the order ends as
// it was. An empty display gives a single word with the empty status.
// Reset clears the fill count, display index, sequencer and strobe; cell
// contents are left as they are. The receiver has no way to stall, so a
// result word is presented for exactly one cycle.
module indexed_insert_delete_array (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  iida_pkg::req_word_t req,
  output iida_pkg::rsp_word_t result,
  output logic                strobe
);
  import iida_pkg::*;

  iida_state_t state, state_next;

  logic [CNT_W-1:0]         count;     // stored entries
  logic [CNT_W-1:0]         step;      // display word index
  logic [CNT_W-1:0]         tail;      // index of the last stored entry
  logic                     accept;
  logic                     ins_ok;
  logic                     del_ok;
  logic                     show_end;
  cell_ctrl_t               ctrl;
  logic signed [WORD_W-1:0] chain [CAPACITY];

  assign tail     = count - CNT_W'(1);
  assign accept   = start && (state == S_IDLE);
  assign show_end = (step == tail);

  // request is legal and will change the store
  assign ins_ok = (req.req_type == REQ_INSERT) && (count < CAP_CNT)
                  && (req.position <= count);
  assign del_ok = (req.req_type == REQ_DELETE) && (count != '0)
                  && (req.position < count);

  // ---------------- cell row ----------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = chain[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = chain[g+1];
    end

    iida_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (CNT_W'(g)),
      .left  (left_w),
      .right (right_w),
      .head  (chain[0]),
      .data  (chain[g])
    );
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (req.req_type == REQ_DISPLAY) && (count != '0)) begin
          state_next = S_SHOW;
        end
      end
      S_SHOW: begin
        if (show_end) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = req.position;
    ctrl.tail  = tail;
    ctrl.value = req.value;
    unique case (state)
      S_IDLE: begin
        if (accept && ins_ok) begin
          ctrl.op = CELL_INS;
        end else if (accept && del_ok) begin
          ctrl.op = CELL_DEL;
        end
      end
      S_SHOW: begin
        busy    = 1'b1;
        ctrl.op = CELL_ROT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // fill count, display index and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      step   <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      result.element_value <= '0;
      result.last          <= 1'b1;
      if (state == S_SHOW) begin
        strobe               <= 1'b1;
        result.element_value <= chain[0];
        result.status        <= STATUS_OK;
        result.fill_count    <= count;
        result.last          <= show_end;
        step                 <= step + CNT_W'(1);
      end else if (accept) begin
        step <= '0;
        result.fill_count <= count;
        priority if (req.req_type == REQ_DISPLAY) begin
          // a non-empty display enters S_SHOW and streams from there
          if (count == '0) begin
            strobe        <= 1'b1;
            result.status <= STATUS_EMPTY;
          end
        end else if (req.req_type == REQ_INSERT) begin
          strobe <= 1'b1;
          if (count >= CAP_CNT) begin
            result.status <= STATUS_FULL;
          end else if (!ins_ok) begin
            result.status <= STATUS_BADPOS;
          end else begin
            result.status     <= STATUS_OK;
            result.fill_count <= count + CNT_W'(1);
            count             <= count + CNT_W'(1);
          end
        end else if (req.req_type == REQ_DELETE) begin
          strobe <= 1'b1;
          if (count == '0) begin
            result.status <= STATUS_EMPTY;
          end else if (!del_ok) begin
            result.status <= STATUS_BADPOS;
          end else begin
            result.status     <= STATUS_OK;
            result.fill_count <= count - CNT_W'(1);
            count             <= count - CNT_W'(1);
          end
        end else begin
          // unused request code: no word, no change
        end
      end
    end
  end

  // ---------------- assertions ----------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("fill count above capacity");

  a_show_emits: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("display cycle without result word");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> busy)
    else $error("non-final word but display ended");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.status == STATUS_FULL)) |-> (result.fill_count == CAP_CNT))
    else $error("overflow reported below capacity");

  a_grow_one: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == CELL_INS) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow count by one");

endmodule

>>> src/iida_cell.sv
module iida_cell (
  input  logic                               clk,
  input  iida_pkg::cell_ctrl_t               ctrl,
  input  logic [iida_pkg::CNT_W-1:0]         idx,
  input  logic signed [iida_pkg::WORD_W-1:0] left,
  input  logic signed [iida_pkg::WORD_W-1:0] right,
  input  logic signed [iida_pkg::WORD_W-1:0] head,
  output logic signed [iida_pkg::WORD_W-1:0] data
);
  import iida_pkg::*;

  // insert: shift up from pos; delete: shift down from pos;
  // rotate: move toward cell 0, tail wraps in the head word
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD: begin
      end
      CELL_INS: begin
        if (idx == ctrl.pos) begin
          data <= ctrl.value;
        end else if (idx > ctrl.pos) begin
          data <= left;
        end
      end
      CELL_DEL: begin
        if (idx >= ctrl.pos) begin
          data <= right;
        end
      end
      CELL_ROT: begin
        if (idx == ctrl.tail) begin
          data <= head;
        end else if (idx < ctrl.tail) begin
          data <= right;
        end
      end
    endcase
  end

endmodule

>>> tb/iida_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the array and checks each
// result word against the oldest expected word.
module iida_checker
  import iida_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  req_word_t req,
  input  rsp_word_t result,
  input  logic      strobe,
  output int        fail_count,
  output int        pending
);

  logic signed [WORD_W-1:0] shadow_cells [CAPACITY];
  logic [CNT_W-1:0]         shadow_fill;
  rsp_word_t                due_words [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic queue_word(input logic signed [WORD_W-1:0] elem, input status_t st,
                            input logic fin);
    rsp_word_t w;
    w.element_value = elem;
    w.status        = st;
    w.fill_count    = shadow_fill;
    w.last          = fin;
    due_words.push_back(w);
  endtask

  task automatic apply_request(input req_word_t w);
    case (req_code_t'(w.req_type))
      REQ_DISPLAY: begin
        if (shadow_fill == '0) begin
          queue_word('0, STATUS_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < int'(shadow_fill); i++)
            queue_word(shadow_cells[i], STATUS_OK, i == int'(shadow_fill) - 1);
        end
      end
      REQ_INSERT: begin
        if (shadow_fill >= CAP_CNT) begin
          queue_word('0, STATUS_FULL, 1'b1);
        end else if (w.position > shadow_fill) begin
          queue_word('0, STATUS_BADPOS, 1'b1);
        end else begin
          for (int i = int'(shadow_fill); i > int'(w.position); i--)
            shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[w.position] = w.value;
          shadow_fill = shadow_fill + 1'b1;
          queue_word('0, STATUS_OK, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (shadow_fill == '0) begin
          queue_word('0, STATUS_EMPTY, 1'b1);
        end else if (w.position >= shadow_fill) begin
          queue_word('0, STATUS_BADPOS, 1'b1);
        end else begin
          for (int i = int'(w.position); i + 1 < int'(shadow_fill); i++)
            shadow_cells[i] = shadow_cells[i+1];
          shadow_fill = shadow_fill - 1'b1;
          queue_word('0, STATUS_OK, 1'b1);
        end
      end
      default: ;  // unused code: no state change, no word
    endcase
  endtask

  always @(posedge clk) begin
    rsp_word_t want;
    logic      bad;
    if (rst) begin
      shadow_fill = '0;
      due_words.delete();
    end else begin
      if (start && !busy)
        apply_request(req);
      if (strobe) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word: value %0d status %0d fill %0d last %0b", $time,
                   result.element_value, result.status, result.fill_count, result.last);
          fail_count <= fail_count + 1;
        end else begin
          want = due_words.pop_front();
          bad  = 1'b0;
          if (result.element_value !== want.element_value) begin
            $display("%0t: element_value expected %0d actual %0d", $time,
                     want.element_value, result.element_value);
            bad = 1'b1;
          end
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, result.status);
            bad = 1'b1;
          end
          if (result.fill_count !== want.fill_count) begin
            $display("%0t: fill_count expected %0d actual %0d", $time,
                     want.fill_count, result.fill_count);
            bad = 1'b1;
          end
          if (result.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, result.last);
            bad = 1'b1;
          end
          if (bad)
            fail_count <= fail_count + 1;
        end
      end
    end
    pending <= due_words.size();
  end

endmodule

>>> tb/tb_indexed_insert_delete_array.sv
`timescale 1ns / 100ps

// Top level: clock, reset, request stimulus and the verdict. All checking
// lives in iida_checker, which reports a failure count and how many result
// words it still waits for.
module tb_indexed_insert_delete_array;
  import iida_pkg::*;

  // request code the block must ignore (no word, no state change)
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         RANDOM_WORDS = 450;

  logic      clk;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  req_word_t req   = '0;
  rsp_word_t result;
  logic      strobe;

  int fail_count;
  int pending;

  // stimulus-side estimate of the fill count, used to aim positions and switch phases
  int fill_est;
  // burst shaping: words left in the current burst
  int burst_left;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  indexed_insert_delete_array DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .result (result),
    .strobe (strobe)
  );

  iida_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .result     (result),
    .strobe     (strobe),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Present one request word and hold it until the block takes it (an edge
  // with start high and busy low). Called at a rising edge; returns at the
  // edge where the word was taken. Between bursts start drops for a random
  // gap, so gaps land both on idle cycles and in the middle of a display.
  task automatic send_word(input logic [1:0] code, input logic [CNT_W-1:0] pos,
                           input logic signed [WORD_W-1:0] val);
    req_word_t w;
    int        gap;
    w.req_type = code;
    w.position = pos;
    w.value    = val;
    gap        = 0;
    if (burst_left == 0) begin
      // one burst in four runs back to back with the previous one
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
    // track fill count so random positions mostly hit the valid range
    if (code == REQ_INSERT && fill_est < CAPACITY && int'(pos) <= fill_est)
      fill_est++;
    else if (code == REQ_DELETE && fill_est != 0 && int'(pos) < fill_est)
      fill_est--;
  endtask

  // stimulus
  initial begin
    int                       done;
    int                       pick;
    logic                     growing;
    logic [1:0]               code;
    logic [CNT_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;

    fill_est   = 0;
    burst_left = 0;
    growing    = 1'b1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, bad positions, field extremes, unused code
    send_word(REQ_DISPLAY, 7'd0,   32'sd0);               // empty display
    send_word(REQ_DELETE,  7'd0,   32'sd0);               // delete on empty
    send_word(REQ_DELETE,  7'd127, -32'sd1);              // delete on empty, pos all ones
    send_word(REQ_INSERT,  7'd1,   32'sd5);               // insert past end
    send_word(REQ_INSERT,  7'd127, -32'sd1);              // insert far past end
    send_word(REQ_INSERT,  7'd0,   32'sh7FFF_FFFF);       // first word, max value
    send_word(REQ_INSERT,  7'd1,   32'sh8000_0000);       // append, min value
    send_word(REQ_INSERT,  7'd0,   -32'sd1);              // insert at front
    send_word(REQ_INSERT,  7'd1,   32'sd0);               // insert in middle
    send_word(REQ_INSERT,  7'd4,   32'sh5A5A_A5A5);       // append at count
    send_word(REQ_DISPLAY, 7'd0,   32'sd0);
    send_word(REQ_UNUSED,  7'd127, -32'sd1);              // ignored
    send_word(REQ_DELETE,  7'd5,   32'sd0);               // delete at count
    send_word(REQ_DELETE,  7'd127, 32'sd0);               // delete far past end
    send_word(REQ_DELETE,  7'd4,   32'sd0);               // delete last
    send_word(REQ_DELETE,  7'd0,   32'sd0);               // delete first
    send_word(REQ_DELETE,  7'd1,   32'sd0);               // delete middle
    send_word(REQ_DISPLAY, 7'd0,   32'sd0);
    send_word(REQ_INSERT,  7'd3,   32'sd9);               // past end, count 2
    send_word(REQ_DELETE,  7'd0,   32'sd0);
    send_word(REQ_DELETE,  7'd0,   32'sd0);               // now empty
    send_word(REQ_DISPLAY, 7'd0,   32'sd0);
    send_word(REQ_UNUSED,  7'd0,   32'sd0);

    // random: alternate fill-up and drain-down phases so the array walks
    // between empty and full; a few words aim outside the valid range
    done = 0;
    while (done < RANDOM_WORDS) begin
      if (fill_est >= CAPACITY && $urandom_range(0, 3) == 0)
        growing = 1'b0;
      else if (fill_est == 0)
        growing = 1'b1;
      else if ($urandom_range(0, 59) == 0)
        growing = ~growing;

      pick = $urandom_range(0, 99);
      if (pick < 7)
        code = REQ_DISPLAY;
      else if (pick < 9)
        code = REQ_UNUSED;
      else if (growing ? (pick < 80) : (pick < 25))
        code = REQ_INSERT;
      else
        code = REQ_DELETE;

      if ($urandom_range(0, 9) == 0)
        pos = CNT_W'($urandom_range(0, 127));
      else if (code == REQ_INSERT)
        pos = CNT_W'($urandom_range(0, (fill_est < CAPACITY) ? fill_est : CAPACITY));
      else
        pos = CNT_W'($urandom_range(0, (fill_est > 0) ? fill_est - 1 : 0));

      case ($urandom_range(0, 19))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        2:       val = 32'sd0;
        3:       val = -32'sd1;
        default: val = $urandom();
      endcase

      send_word(code, pos, val);
      if (code != REQ_UNUSED)
        done++;
    end
    start <= 1'b0;

    // drain: pending is registered behind the last request, so step past it
    // before waiting for every expected word, then let the clock run quietly
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("indexed_insert_delete_array regression: pass");
    else
      $display("indexed_insert_delete_array regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("indexed_insert_delete_array regression: fail");
    $finish;
  end

endmodule
